// ----- src/imgds_pkg.sv -----
package imgds_pkg;

  localparam int PIX_W = 16;
  localparam int PAIR_W = PIX_W + 1;
  localparam int TOTAL_W = PIX_W + 2;
  localparam int CFG_W_W = 11;
  localparam int CFG_H_W = 16;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [CFG_W_W-1:0] WIDTH_RESET = 11'd640;
  localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 16'd480;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage

// ----- src/image_downsample_2x2_average.sv -----
// 2x2 box-filter downsampler for a grayscale raster stream.
// The input channel (in_valid, in_stall, in_pixel_value) takes one pixel per
// item in raster order. The output channel (out_valid, out_stall,
// out_block_mean, out_last_of_image) gives one mean for each complete 2x2
// block, emitted on the bottom-right pixel of that block; out_last_of_image
// marks the final block of an image, after which the counters wrap.
// Image size is set through the APB port: image_width at address 0 and
// image_height at address 4; write them only while the block is idle.
// An item can be taken every cycle while in_stall is low. A result passes
// through the line store read into the read stage, then through the add
// into the output register. Even rows keep their pair sums in a single-port
// line store of MAX_WIDTH/2 entries; odd rows read them back.
// When the receiver stalls, the output register holds its result and one more
// result may wait in the read stage; only when both are full is in_stall
// raised. Reset clears the counters and pipeline valids and loads the default
// size of 640 by 480; the line store needs no clearing.
module image_downsample_2x2_average #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [imgds_pkg::PIX_W-1:0]   in_pixel_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [imgds_pkg::PIX_W-1:0]   out_block_mean,
  output logic                          out_last_of_image,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [imgds_pkg::ADDR_W-1:0]  paddr,
  input  logic [imgds_pkg::DATA_W-1:0]  pwdata,
  output logic [imgds_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LAW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int WW = ($clog2(MAX_WIDTH + 1) > imgds_pkg::CFG_W_W) ?
                      $clog2(MAX_WIDTH + 1) : imgds_pkg::CFG_W_W;
  localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);

  logic [imgds_pkg::CFG_W_W-1:0] width_r;
  logic [imgds_pkg::CFG_H_W-1:0] height_r;
  logic                          cfg_we;

  logic [CW-1:0]                 col_r;
  logic [imgds_pkg::CFG_H_W-1:0] row_r;
  logic [imgds_pkg::PIX_W-1:0]   first_r;

  logic [WW-1:0]                 w_raw;
  logic [WW-1:0]                 w_eff;
  logic [WW-1:0]                 w_last;
  logic [WW-1:0]                 w_even;
  logic [WW-1:0]                 col_ext;
  logic [imgds_pkg::CFG_H_W-1:0] h_eff;
  logic [imgds_pkg::CFG_H_W-1:0] h_last;
  logic [imgds_pkg::CFG_H_W-1:0] h_even;

  logic                          in_acc;
  logic                          active;
  logic                          mem_we;
  logic                          rd_en;
  logic                          last_blk;
  logic [LAW-1:0]                line_idx;
  logic [imgds_pkg::PAIR_W-1:0]  pair_sum;

  logic [imgds_pkg::PAIR_W-1:0]  line_mem [LINE_DEPTH];
  logic [imgds_pkg::PAIR_W-1:0]  rdata_r;

  logic                          s1_v_r;
  logic [imgds_pkg::PAIR_W-1:0]  pair_r;
  logic                          last_r;
  logic                          s1_adv;
  logic [imgds_pkg::TOTAL_W-1:0] total;

  logic                          out_valid_r;
  logic [imgds_pkg::PIX_W-1:0]   mean_r;
  logic                          out_last_r;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= imgds_pkg::WIDTH_RESET;
      height_r <= imgds_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (imgds_pkg::cfg_reg_t'(paddr[2]))
        imgds_pkg::REG_WIDTH:  width_r  <= pwdata[imgds_pkg::CFG_W_W-1:0];
        imgds_pkg::REG_HEIGHT: height_r <= pwdata[imgds_pkg::CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (imgds_pkg::cfg_reg_t'(paddr[2]))
      imgds_pkg::REG_WIDTH:  prdata = imgds_pkg::DATA_W'(width_r);
      imgds_pkg::REG_HEIGHT: prdata = imgds_pkg::DATA_W'(height_r);
      default:               prdata = '0;
    endcase
  end

  // Effective image size: zero acts as one, width saturates at the line store.
  always_comb begin
    w_raw = WW'(width_r);
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (w_raw > MAX_W) begin
      w_eff = MAX_W;
    end else begin
      w_eff = w_raw;
    end
    w_last  = w_eff - WW'(1);
    w_even  = w_eff & ~WW'(1);
    col_ext = WW'(col_r);
    h_eff   = (height_r == '0) ? imgds_pkg::CFG_H_W'(1) : height_r;
    h_last  = h_eff - imgds_pkg::CFG_H_W'(1);
    h_even  = h_eff & ~imgds_pkg::CFG_H_W'(1);
  end

  assign in_stall = s1_v_r && out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign active   = (col_ext < w_even) && (row_r < h_even);
  assign mem_we   = in_acc && active && col_r[0] && !row_r[0];
  assign rd_en    = in_acc && active && col_r[0] && row_r[0];
  assign last_blk = (row_r == h_even - imgds_pkg::CFG_H_W'(1)) &&
                    (col_ext == w_even - WW'(1));
  assign line_idx = LAW'(col_r >> 1);
  assign pair_sum = imgds_pkg::PAIR_W'(first_r) + imgds_pkg::PAIR_W'(in_pixel_value);

  // Raster counters and first pixel of each horizontal pair.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      first_r <= '0;
    end else if (in_acc) begin
      if (active && !col_r[0]) begin
        first_r <= in_pixel_value;
      end
      if (col_ext >= w_last) begin
        col_r <= '0;
        row_r <= (row_r >= h_last) ? '0 : row_r + imgds_pkg::CFG_H_W'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // Line store of even-row pair sums. A read always follows the write of the
  // same entry by at least one row, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[line_idx] <= pair_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= line_mem[line_idx];
    end
  end

  // Read stage: waits for the line store data and holds while the output is full.
  assign s1_adv = s1_v_r && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rd_en) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pair_r <= pair_sum;
      last_r <= last_blk;
    end
  end

  assign total = imgds_pkg::TOTAL_W'(rdata_r) + imgds_pkg::TOTAL_W'(pair_r);

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mean_r     <= total[imgds_pkg::TOTAL_W-1:2];
      out_last_r <= last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_block_mean    = mean_r;
  assign out_last_of_image = out_last_r;

  a_read_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> s1_v_r)
    else $error("line store read did not fill the read stage");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_adv && !rd_en |=> s1_v_r && $stable(pair_r) && $stable(rdata_r))
    else $error("blocked read stage lost its contents");

  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_v_r))
    else $error("result appeared without a waiting read stage");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_r) < MAX_W)
    else $error("column counter beyond the line store width");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_W = 1024;
  localparam int LINE_ENTRIES = MAX_W / 2;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  localparam int TOTAL_ITEMS = 850;

  typedef logic [imgds_pkg::PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t mean;
    logic last;
  } block_res_t;

  typedef struct {
    bit                  is_cfg;
    imgds_pkg::cfg_reg_t reg_sel;
    int unsigned         value;
    pix_t                pix;
    bit                  typed;
    block_res_t          res;
  } dir_row_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  pix_t                         in_pixel_value;
  logic                         out_valid;
  logic                         out_stall;
  pix_t                         out_block_mean;
  logic                         out_last_of_image;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [imgds_pkg::ADDR_W-1:0] paddr;
  logic [imgds_pkg::DATA_W-1:0] pwdata;
  logic [imgds_pkg::DATA_W-1:0] prdata;
  logic                         pready;

  image_downsample_2x2_average #(
    .MAX_WIDTH(MAX_W)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_value   (in_pixel_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_block_mean   (out_block_mean),
    .out_last_of_image(out_last_of_image),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  logic [imgds_pkg::CFG_W_W-1:0] cur_width;
  logic [imgds_pkg::CFG_H_W-1:0] cur_height;
  logic [imgds_pkg::PAIR_W-1:0]  pair_line [LINE_ENTRIES];
  pix_t                          first_pix;
  int unsigned                   col_cnt;
  int unsigned                   row_cnt;

  block_res_t pending_means[$];
  int         fail_count = 0;
  int         items_sent = 0;
  bit         in_idle_on = 1'b1;
  bit         out_idle_on = 1'b1;
  int         hold_requests = 0;
  int         holds_taken = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit predict_block_mean(input pix_t pix, output block_res_t res);
    int unsigned w, h, w_even, h_even, idx;
    logic [imgds_pkg::PAIR_W-1:0]  pair;
    logic [imgds_pkg::TOTAL_W-1:0] total;
    bit produced;
    w = 32'(cur_width);
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    h = 32'(cur_height);
    if (h == 0) h = 1;
    w_even = w & ~32'd1;
    h_even = h & ~32'd1;
    produced = 1'b0;
    res = '0;
    if (col_cnt < w_even && row_cnt < h_even) begin
      if (col_cnt % 2 == 0) begin
        first_pix = pix;
      end else begin
        pair = imgds_pkg::PAIR_W'(first_pix) + imgds_pkg::PAIR_W'(pix);
        idx = (col_cnt / 2) % LINE_ENTRIES;
        if (row_cnt % 2 == 0) begin
          pair_line[idx] = pair;
        end else begin
          total = imgds_pkg::TOTAL_W'(pair_line[idx]) + imgds_pkg::TOTAL_W'(pair);
          res.mean = total[imgds_pkg::TOTAL_W-1:2];
          res.last = (row_cnt == h_even - 1) && (col_cnt == w_even - 1);
          produced = 1'b1;
        end
      end
    end
    if (col_cnt >= w - 1) begin
      col_cnt = 0;
      if (row_cnt >= h - 1) row_cnt = 0;
      else row_cnt = (row_cnt + 1) & 32'hFFFF;
    end else begin
      col_cnt = col_cnt + 1;
    end
    return produced;
  endfunction

  function automatic pix_t rand_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return pix_t'($urandom());
    endcase
  endfunction

  function automatic dir_row_t cfg_row(input imgds_pkg::cfg_reg_t sel,
                                       input int unsigned value);
    dir_row_t r;
    r.is_cfg = 1'b1;
    r.reg_sel = sel;
    r.value = value;
    r.pix = '0;
    r.typed = 1'b0;
    r.res = '0;
    return r;
  endfunction

  function automatic dir_row_t pix_row(input pix_t pix, input bit typed = 1'b0,
                                       input block_res_t res = '0);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.reg_sel = imgds_pkg::REG_WIDTH;
    r.value = 0;
    r.pix = pix;
    r.typed = typed;
    r.res = res;
    return r;
  endfunction

  task automatic send_pixel(input pix_t pix, input bit typed = 1'b0,
                            input block_res_t typed_res = '0);
    int gap;
    block_res_t res;
    bit produced;
    gap = in_idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_value <= pix;
    do @(posedge clk); while (in_stall);
    produced = predict_block_mean(pix, res);
    items_sent++;
    if (typed) pending_means.push_back(typed_res);
    else if (produced) pending_means.push_back(res);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_read_check(input imgds_pkg::cfg_reg_t sel,
                                input logic [imgds_pkg::DATA_W-1:0] expected);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {sel, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== expected) begin
      $error("%s: expected %0d, got %0d",
             (sel == imgds_pkg::REG_WIDTH) ? "image_width" : "image_height",
             expected, prdata);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_write(input imgds_pkg::cfg_reg_t sel, input int unsigned value);
    int unsigned mask;
    mask = (sel == imgds_pkg::REG_WIDTH) ? (32'd1 << imgds_pkg::CFG_W_W) - 1 :
                                           (32'd1 << imgds_pkg::CFG_H_W) - 1;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= ($urandom() & ~mask) | (value & mask);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (sel == imgds_pkg::REG_WIDTH) cur_width = value[imgds_pkg::CFG_W_W-1:0];
    else cur_height = value[imgds_pkg::CFG_H_W-1:0];
    cfg_read_check(sel, value & mask);
  endtask

  task automatic set_size(input int unsigned w, input int unsigned h);
    wait_drained();
    cfg_write(imgds_pkg::REG_WIDTH, w);
    cfg_write(imgds_pkg::REG_HEIGHT, h);
  endtask

  task automatic run_images(input int unsigned w, input int unsigned h, input int n);
    set_size(w, h);
    repeat (n) begin
      do send_pixel(rand_pixel()); while (col_cnt != 0 || row_cnt != 0);
    end
  endtask

  // The size changes part way through an image; the counters then run on
  // against the new size until the image wraps.
  task automatic run_resize(input int unsigned w1, input int unsigned h1, input int n1,
                            input int unsigned w2, input int unsigned h2);
    set_size(w1, h1);
    repeat (n1) send_pixel(rand_pixel());
    set_size(w2, h2);
    while (col_cnt != 0 || row_cnt != 0) send_pixel(rand_pixel());
  endtask

  initial begin : receiver
    int wait_n;
    int hold_left;
    block_res_t want;
    wait_n = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (pending_means.size() == 0) begin
          $error("unexpected result: block_mean %0h, last_of_image %0b",
                 out_block_mean, out_last_of_image);
          fail_count++;
        end else begin
          want = pending_means.pop_front();
          if (out_block_mean !== want.mean) begin
            $error("block_mean: expected %0h, got %0h", want.mean, out_block_mean);
            fail_count++;
          end
          if (out_last_of_image !== want.last) begin
            $error("last_of_image: expected %0b, got %0b", want.last, out_last_of_image);
            fail_count++;
          end
        end
        wait_n = out_idle_on ? $urandom_range(0, 16) : 0;
      end
      if (hold_requests != holds_taken) begin
        holds_taken = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (wait_n > 0) begin
        wait_n--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    dir_row_t rows[$];
    int unsigned w, h, w2, h2;
    int n;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_pixel_value <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cur_width = imgds_pkg::WIDTH_RESET;
    cur_height = imgds_pkg::HEIGHT_RESET;
    first_pix = '0;
    col_cnt = 0;
    row_cnt = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_read_check(imgds_pkg::REG_WIDTH, imgds_pkg::DATA_W'(imgds_pkg::WIDTH_RESET));
    cfg_read_check(imgds_pkg::REG_HEIGHT, imgds_pkg::DATA_W'(imgds_pkg::HEIGHT_RESET));

    rows.push_back(cfg_row(imgds_pkg::REG_WIDTH, 2));
    rows.push_back(cfg_row(imgds_pkg::REG_HEIGHT, 2));
    repeat (3) rows.push_back(pix_row(16'hFFFF));
    rows.push_back(pix_row(16'hFFFF, 1'b1, block_res_t'{16'hFFFF, 1'b1}));
    rows.push_back(pix_row(16'd0));
    rows.push_back(pix_row(16'd2));
    rows.push_back(pix_row(16'd3));
    rows.push_back(pix_row(16'd6, 1'b1, block_res_t'{16'd2, 1'b1}));
    rows.push_back(cfg_row(imgds_pkg::REG_WIDTH, 3));
    rows.push_back(cfg_row(imgds_pkg::REG_HEIGHT, 3));
    rows.push_back(pix_row(16'd4));
    rows.push_back(pix_row(16'd8));
    rows.push_back(pix_row(16'd100));
    rows.push_back(pix_row(16'd12));
    rows.push_back(pix_row(16'd16, 1'b1, block_res_t'{16'd10, 1'b1}));
    repeat (4) rows.push_back(pix_row(16'd100));
    rows.push_back(cfg_row(imgds_pkg::REG_WIDTH, 0));
    rows.push_back(cfg_row(imgds_pkg::REG_HEIGHT, 2));
    rows.push_back(pix_row(16'd7));
    rows.push_back(pix_row(16'd9));
    rows.push_back(cfg_row(imgds_pkg::REG_WIDTH, 2));
    rows.push_back(cfg_row(imgds_pkg::REG_HEIGHT, 0));
    rows.push_back(pix_row(16'd5));
    rows.push_back(pix_row(16'd11));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_drained();
        cfg_write(rows[i].reg_sel, rows[i].value);
      end else begin
        send_pixel(rows[i].pix, rows[i].typed, rows[i].res);
      end
    end

    // Two rows at the widest resize width fill every line store entry that a
    // later resize can read.
    run_images(24, 2, 1);
    in_idle_on = 1'b0;
    hold_requests++;
    run_images(16, 8, 1);
    in_idle_on = 1'b1;

    while (items_sent < TOTAL_ITEMS) begin
      in_idle_on = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        w = $urandom_range(4, 24);
        h = $urandom_range(2, 8);
        n = $urandom_range(1, w * h - 1);
        w2 = $urandom_range(0, 12);
        h2 = $urandom_range(0, 6);
        run_resize(w, h, n, w2, h2);
      end else begin
        case ($urandom_range(0, 9))
          0: w = $urandom_range(0, 1);
          1: w = $urandom_range(13, 32);
          default: w = $urandom_range(2, 12);
        endcase
        case ($urandom_range(0, 9))
          0: h = $urandom_range(0, 1);
          1: h = $urandom_range(9, 12);
          default: h = $urandom_range(2, 8);
        endcase
        n = (w > 12 || h > 8) ? 1 : $urandom_range(1, 3);
        run_images(w, h, n);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- image_downsample_2x2_average.f -----
src/imgds_pkg.sv
src/image_downsample_2x2_average.sv
tb/tb_top.sv
